// ===== src/grc_pkg.sv =====
package grc_pkg;

  localparam int SCREEN_WIDTH_DEF = 640;
  localparam int MAP_SIZE_DEF     = 8;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WALLS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd7;

  localparam logic [15:0] POS_X_RST   = 16'd32768;
  localparam logic [15:0] POS_Y_RST   = 16'd32768;
  localparam logic [15:0] DIR_X_RST   = 16'hC000;
  localparam logic [15:0] DIR_Y_RST   = 16'h0000;
  localparam logic [15:0] PLANE_X_RST = 16'h0000;
  localparam logic [15:0] PLANE_Y_RST = 16'd10813;
  localparam logic [63:0] WALLS_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [9:0]  HEIGHT_RST  = 10'd480;

  // divider widths
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 40;

  localparam int CAM_W   = 26;
  localparam int PROD_W  = 42;
  localparam int RAY_W   = 29;
  localparam int DELTA_W = 33;
  localparam int T_W     = 40;
  localparam int LH_W    = 27;
  localparam int STEP_W  = 6;
  localparam int MAP_W   = 5;

  localparam logic [CAM_W-1:0]   ONE_Q14   = 26'd16384;
  localparam logic [13:0]        ONE_Q13   = 14'd8192;
  localparam logic [DIV_NW-1:0]  ONE_Q30   = 31'h4000_0000;
  localparam logic [DELTA_W-1:0] DELTA_SAT = 33'h1_0000_0000;
  localparam logic [LH_W-1:0]    LH_SAT    = 27'h400_0000;
  localparam logic [STEP_W-1:0]  STEP_MAX  = 6'd36;

  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_DX   = 2'd1;
  localparam logic [1:0] DIV_DY   = 2'd2;
  localparam logic [1:0] DIV_LH   = 2'd3;

  typedef struct packed {
    logic       col_load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cam_load;
    logic       ray_load;
    logic       dx_load;
    logic       dy_load;
    logic       side_mul;
    logic       side_sum;
    logic       dda_step;
    logic       lh_load;
    logic       out_load;
  } grc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic dda_hit;
  } grc_sts_t;

endpackage

// ===== src/grid_raycast_column_top.sv =====
// One screen column per request: the column becomes a camera offset and a ray, the ray is
// walked through the 8x8 wall bitmap cell by cell, and the result is the first and last
// wall rows plus the face that was hit. The camera offset is a multiplication by a constant
// reciprocal of the screen width, three divisions (two step distances, line height) share
// one divider that makes one quotient bit per cycle, and the cell walk makes up to 36 steps.
// A new column is taken only when the previous one has reached the output register, and it
// may be taken while that result still waits; a result that is still held when the next one
// is ready delays it by the remaining stall cycles. The user must write registers through the
// write port only while no column is in flight; the block itself does not enforce this.
module grid_raycast_column_top #(
  parameter int SCREEN_WIDTH = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int MAP_SIZE     = grc_pkg::MAP_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [9:0]                     column,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [9:0]                     draw_start,
  output logic [9:0]                     draw_end,
  output logic                           hit_side
);

  grc_pkg::grc_cmd_t cmd;
  grc_pkg::grc_sts_t sts;

  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  grc_datapath #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .MAP_SIZE(MAP_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .column     (column),
    .cmd        (cmd),
    .sts        (sts),
    .draw_start (draw_start),
    .draw_end   (draw_end),
    .hit_side   (hit_side)
  );

endmodule

// ===== src/grc_div.sv =====
module grc_div #(
  parameter int NW = grc_pkg::DIV_NW,
  parameter int DW = grc_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial    = {rem, quo[NW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], fits};
      if (fits) begin
        rem <= DW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

endmodule

// ===== src/grc_ctrl.sv =====
module grc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output grc_pkg::grc_cmd_t cmd,
  input  grc_pkg::grc_sts_t sts
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CAM     = 4'd1;
  localparam logic [3:0] S_RAY     = 4'd3;
  localparam logic [3:0] S_DX_GO   = 4'd4;
  localparam logic [3:0] S_DX_WT   = 4'd5;
  localparam logic [3:0] S_DY_GO   = 4'd6;
  localparam logic [3:0] S_DY_WT   = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_SUM     = 4'd9;
  localparam logic [3:0] S_DDA     = 4'd10;
  localparam logic [3:0] S_LH_GO   = 4'd11;
  localparam logic [3:0] S_LH_WT   = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.col_load = 1'b1;
          state_next = S_CAM;
        end
      end
      S_CAM: begin
        cmd.cam_load = 1'b1;
        state_next = S_RAY;
      end
      S_RAY: begin
        cmd.ray_load = 1'b1;
        state_next = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = grc_pkg::DIV_DX;
        state_next = S_DX_WT;
      end
      S_DX_WT: begin
        if (sts.div_done) begin
          cmd.dx_load = 1'b1;
          state_next = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = grc_pkg::DIV_DY;
        state_next = S_DY_WT;
      end
      S_DY_WT: begin
        if (sts.div_done) begin
          cmd.dy_load = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.side_mul = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.side_sum = 1'b1;
        state_next = S_DDA;
      end
      S_DDA: begin
        cmd.dda_step = 1'b1;
        if (sts.dda_hit) begin
          state_next = S_LH_GO;
        end
      end
      S_LH_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = grc_pkg::DIV_LH;
        state_next = S_LH_WT;
      end
      S_LH_WT: begin
        if (sts.div_done) begin
          cmd.lh_load = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_CAM)
    else $error("accepted request did not start work");
  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a held result");
  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DX_WT || state == S_DY_WT || state == S_LH_WT))
    else $error("divider finished outside a wait state");
  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result shown without finishing a column");
`endif

endmodule

// ===== src/grc_datapath.sv =====
module grc_datapath #(
  parameter int SCREEN_WIDTH = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int MAP_SIZE     = grc_pkg::MAP_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [9:0]                      column,
  input  grc_pkg::grc_cmd_t               cmd,
  output grc_pkg::grc_sts_t               sts,
  output logic [9:0]                      draw_start,
  output logic [9:0]                      draw_end,
  output logic                            hit_side
);

  localparam int NW     = grc_pkg::DIV_NW;
  localparam int DW     = grc_pkg::DIV_DW;
  localparam int CAM_W  = grc_pkg::CAM_W;
  localparam int PROD_W = grc_pkg::PROD_W;
  localparam int RAY_W  = grc_pkg::RAY_W;
  localparam int DEL_W  = grc_pkg::DELTA_W;
  localparam int T_W    = grc_pkg::T_W;
  localparam int LH_W   = grc_pkg::LH_W;
  localparam int STEP_W = grc_pkg::STEP_W;
  localparam int MAP_W  = grc_pkg::MAP_W;

  // column * 2^15 / width as column * ceil(2^35 / width) / 2^20, exact for 10 bit columns
  localparam longint CAM_RECIP_L = ((64'sd1 <<< 35) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam logic [34:0] CAM_RECIP = 35'(CAM_RECIP_L);

  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] plane_x;
  logic signed [15:0] plane_y;
  logic [63:0]        wall_map;
  logic [9:0]         scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x    <= grc_pkg::POS_X_RST;
      pos_y    <= grc_pkg::POS_Y_RST;
      dir_x    <= grc_pkg::DIR_X_RST;
      dir_y    <= grc_pkg::DIR_Y_RST;
      plane_x  <= grc_pkg::PLANE_X_RST;
      plane_y  <= grc_pkg::PLANE_Y_RST;
      wall_map <= grc_pkg::WALLS_RST;
      scr_h    <= grc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grc_pkg::REG_POS_X:   pos_x    <= cfg_data[15:0];
        grc_pkg::REG_POS_Y:   pos_y    <= cfg_data[15:0];
        grc_pkg::REG_DIR_X:   dir_x    <= cfg_data[15:0];
        grc_pkg::REG_DIR_Y:   dir_y    <= cfg_data[15:0];
        grc_pkg::REG_PLANE_X: plane_x  <= cfg_data[15:0];
        grc_pkg::REG_PLANE_Y: plane_y  <= cfg_data[15:0];
        grc_pkg::REG_WALLS:   wall_map <= cfg_data;
        grc_pkg::REG_HEIGHT:  scr_h    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [9:0]              col;
  logic signed [CAM_W-1:0] cam;
  logic signed [RAY_W-1:0] ray_x;
  logic signed [RAY_W-1:0] ray_y;
  logic [RAY_W-1:0]        mag_x;
  logic [RAY_W-1:0]        mag_y;
  logic [DEL_W-1:0]        delta_x;
  logic [DEL_W-1:0]        delta_y;
  logic [30:0]             plo_x;
  logic [30:0]             plo_y;
  logic [29:0]             phi_x;
  logic [29:0]             phi_y;
  logic [T_W-1:0]          t_x;
  logic [T_W-1:0]          t_y;
  logic [T_W-1:0]          perp;
  logic signed [MAP_W-1:0] map_x;
  logic signed [MAP_W-1:0] map_y;
  logic [STEP_W-1:0]       cnt;
  logic                    side;
  logic [LH_W-1:0]         lh;
  logic [44:0]             cam_prod;

  // divider operands and results
  logic          div_done;
  logic [NW-1:0] div_q;
  logic [NW-1:0] div_n;
  logic [DW-1:0] div_d;

  assign cam_prod = 45'(col) * 45'(CAM_RECIP);

  assign mag_x = ray_x[RAY_W-1] ? RAY_W'(-ray_x) : RAY_W'(ray_x);
  assign mag_y = ray_y[RAY_W-1] ? RAY_W'(-ray_y) : RAY_W'(ray_y);

  always_comb begin
    unique case (cmd.div_sel)
      grc_pkg::DIV_NONE: begin
        div_n = '0;
        div_d = '0;
      end
      grc_pkg::DIV_DX: begin
        div_n = grc_pkg::ONE_Q30;
        div_d = DW'(mag_x);
      end
      grc_pkg::DIV_DY: begin
        div_n = grc_pkg::ONE_Q30;
        div_d = DW'(mag_y);
      end
      grc_pkg::DIV_LH: begin
        div_n = NW'({scr_h, 16'b0});
        div_d = perp;
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  grc_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  // ray and first side distances
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic [13:0]              frac_x;
  logic [13:0]              frac_y;
  logic [46:0]              sum_x;
  logic [46:0]              sum_y;

  assign prod_x = plane_x * cam;
  assign prod_y = plane_y * cam;
  assign frac_x = ray_x[RAY_W-1] ? {1'b0, pos_x[12:0]}
                                 : grc_pkg::ONE_Q13 - {1'b0, pos_x[12:0]};
  assign frac_y = ray_y[RAY_W-1] ? {1'b0, pos_y[12:0]}
                                 : grc_pkg::ONE_Q13 - {1'b0, pos_y[12:0]};
  assign sum_x = {phi_x, 17'b0} + 47'(plo_x);
  assign sum_y = {phi_y, 17'b0} + 47'(plo_y);

  // dda step
  logic                    step_x;
  logic [T_W-1:0]          t_x_next;
  logic [T_W-1:0]          t_y_next;
  logic signed [MAP_W-1:0] map_x_next;
  logic signed [MAP_W-1:0] map_y_next;
  logic [STEP_W-1:0]       cnt_next;
  logic                    outside;
  logic [5:0]              map_bit;

  assign step_x = t_x < t_y;
  assign t_x_next = step_x ? t_x + T_W'(delta_x) : t_x;
  assign t_y_next = step_x ? t_y : t_y + T_W'(delta_y);
  assign map_x_next = step_x ? map_x + (ray_x[RAY_W-1] ? 5'sh1f : 5'sh01) : map_x;
  assign map_y_next = step_x ? map_y : map_y + (ray_y[RAY_W-1] ? 5'sh1f : 5'sh01);
  assign cnt_next = cnt + STEP_W'(1);
  assign outside = map_x_next[MAP_W-1] || map_y_next[MAP_W-1] ||
                   (map_x_next[3:0] >= 4'(MAP_SIZE)) ||
                   (map_y_next[3:0] >= 4'(MAP_SIZE));
  assign map_bit = {map_x_next[2:0], map_y_next[2:0]};

  assign sts.div_done = div_done;
  assign sts.dda_hit  = outside || wall_map[map_bit] || cnt_next == grc_pkg::STEP_MAX;

  // span
  logic [25:0] lh_half;
  logic [8:0]  h_half;
  logic [25:0] ds_diff;
  logic [26:0] de_sum;

  assign lh_half = lh[LH_W-1:1];
  assign h_half  = scr_h[9:1];
  assign ds_diff = 26'(h_half) - lh_half;
  assign de_sum  = 27'(lh_half) + 27'(h_half);

  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      col <= column;
    end
    if (cmd.cam_load) begin
      cam <= CAM_W'(cam_prod[44:20]) - grc_pkg::ONE_Q14;
    end
    if (cmd.ray_load) begin
      ray_x <= RAY_W'(prod_x >>> 14) + RAY_W'(dir_x);
      ray_y <= RAY_W'(prod_y >>> 14) + RAY_W'(dir_y);
    end
    if (cmd.dx_load) begin
      delta_x <= (mag_x == '0) ? grc_pkg::DELTA_SAT : DEL_W'(div_q);
    end
    if (cmd.dy_load) begin
      delta_y <= (mag_y == '0) ? grc_pkg::DELTA_SAT : DEL_W'(div_q);
    end
    if (cmd.side_mul) begin
      plo_x <= 31'(frac_x) * 31'(delta_x[16:0]);
      plo_y <= 31'(frac_y) * 31'(delta_y[16:0]);
      phi_x <= 30'(frac_x) * 30'(delta_x[32:17]);
      phi_y <= 30'(frac_y) * 30'(delta_y[32:17]);
    end
    if (cmd.side_sum) begin
      t_x   <= T_W'(sum_x[46:13]);
      t_y   <= T_W'(sum_y[46:13]);
      map_x <= {2'b00, pos_x[15:13]};
      map_y <= {2'b00, pos_y[15:13]};
      cnt   <= '0;
      side  <= 1'b1;
    end
    if (cmd.dda_step) begin
      t_x   <= t_x_next;
      t_y   <= t_y_next;
      map_x <= map_x_next;
      map_y <= map_y_next;
      cnt   <= cnt_next;
      side  <= !step_x;
      perp  <= step_x ? t_x : t_y;
    end
    if (cmd.lh_load) begin
      lh <= (div_q > NW'(grc_pkg::LH_SAT)) ? grc_pkg::LH_SAT : div_q[LH_W-1:0];
    end
    if (cmd.out_load) begin
      draw_start <= (26'(h_half) > lh_half) ? ds_diff[9:0] : 10'd0;
      if (de_sum >= 27'(scr_h)) begin
        draw_end <= (scr_h == 10'd0) ? 10'd0 : scr_h - 10'd1;
      end else begin
        draw_end <= de_sum[9:0];
      end
      hit_side <= side;
    end
  end

endmodule
